/* sv/assert_macros.svh */
// assertion macros shared by the clustering block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge outside reset
`define THPC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// implication checked in the same cycle
`define THPC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the next cycle
`define THPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/thpc_pkg.sv */
// shared types and constants of the threshold point clustering block
`default_nettype none

package thpc_pkg;

   localparam int COORD_W    = 16;
   localparam int NUM_COORDS = 4;
   localparam int CID_OUT_W  = 10;
   localparam int CNT_OUT_W  = 11;
   localparam int THRESH_W   = 16;
   localparam int DIMS_W     = 3;

   // configuration register indexes
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_DIMS      = 1'b1;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd256;
   localparam logic [DIMS_W-1:0]   DIMS_RESET   = 3'd3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [NUM_COORDS-1:0][COORD_W-1:0] coord_vec_type;

   // distance unit result for one stored point
   typedef struct packed {
      logic valid;
      logic in_range;
   } dist_res_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

/* sv/thpc_dist.sv */
// pipelined squared distance and threshold compare, one stored point per cycle
`default_nettype none

module thpc_dist #(
   parameter int MAX_DIMS = 4,
   parameter int IW       = 10
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       in_valid,
   input  wire logic [MAX_DIMS-1:0][thpc_pkg::COORD_W-1:0] pt,
   input  wire logic [MAX_DIMS-1:0][thpc_pkg::COORD_W-1:0] st,
   input  wire logic [IW-1:0]                              in_cid,
   input  wire logic [thpc_pkg::DIMS_W-1:0]                dims_eff,
   input  wire logic [31:0]                                th2,
   output thpc_pkg::dist_res_type                          res,
   output logic [IW-1:0]                                   res_cid
);

   logic [MAX_DIMS-1:0][31:0] sq_ff, sq_in;
   logic                      valid_ff;
   logic [IW-1:0]             cid_ff;
   logic signed [16:0]        diff [MAX_DIMS];
   logic signed [33:0]        sq_full [MAX_DIMS];
   logic [33:0]               sum;

   // per-coordinate squared differences, unused coordinates forced to zero
   always_comb begin
      for (int j = 0; j < MAX_DIMS; j++) begin
         diff[j]    = 17'($signed(pt[j])) - 17'($signed(st[j]));
         sq_full[j] = diff[j] * diff[j];
         sq_in[j]   = (3'(j) < dims_eff) ? sq_full[j][31:0] : 32'd0;
      end
   end

   // square stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      sq_ff  <= sq_in;
      cid_ff <= in_cid;
   end

   // sum and compare
   always_comb begin
      sum = '0;
      for (int j = 0; j < MAX_DIMS; j++) begin
         sum = sum + 34'(sq_ff[j]);
      end
      res.valid    = valid_ff;
      res.in_range = (sum <= {2'b00, th2});
      res_cid      = cid_ff;
   end

endmodule

`default_nettype wire

/* sv/thpc_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none

`include "assert_macros.svh"

module thpc_div #(
   parameter int NW = 27,
   parameter int CW = 11
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [NW-1:0]           dividend,
   input  wire logic [CW-1:0]           den,
   output thpc_pkg::div_status_type     stat,
   output logic [NW-1:0]                quo
);

   localparam int SW = $clog2(NW + 1);

   logic [CW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [CW-1:0] den_ff;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW:0]   shifted;
   logic [CW:0]   trial;
   logic          ge;

   // start load, or one shift and subtract step while busy
   always_comb begin
      shifted = {rem_ff, quo_ff[NW-1]};
      trial   = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = SW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? trial[CW-1:0] : shifted[CW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = quo_ff;

   `THPC_ASSERT_IMP(a_rem_below_den, busy_ff, rem_ff < den_ff, "divider remainder not below divisor")
   `THPC_ASSERT_IMP(a_done_not_busy, done_ff, !busy_ff, "divider done while still busy")

endmodule

`default_nettype wire

/* sv/threshold_point_clustering.sv */
// top level of the threshold point clustering block
//
// Input transactions (req_) carry one point of up to four signed Q8.8
// coordinates and a start flag that empties the stores first. Each accepted
// transaction gives exactly one result transaction (rsp_): the cluster the
// point joined or created, a new-cluster flag, the member count, the centroid
// and a store-full flag for a dropped point. Configuration (csr_) writes the
// distance threshold (index 0) and the dimension count (index 1).
// One point at a time: req_ready is high only while no point is in work.
// The stored points are scanned through one pipelined distance unit, one per
// cycle; a point within range of none opens a new cluster. Joining a cluster adds
// the running-mean update, one coordinate after another through one shared
// restoring divider (fetch, multiply, divider start, divide), then the write.
// A dropped point (store full) skips the scan and goes straight to the result.
// The result waits in an output register; a stalled receiver does not stop
// the next point from being accepted, only from being finished.
// Reset empties the stores (counts to zero), sets the threshold to 1.0 and
// the dimension count to three; the memories need no clearing.
`default_nettype none

`include "assert_macros.svh"

module threshold_point_clustering #(
   parameter int MAX_POINTS = 1024,
   parameter int MAX_DIMS   = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_start_new_set,
   input  wire logic signed [thpc_pkg::COORD_W-1:0]  req_coord_0,
   input  wire logic signed [thpc_pkg::COORD_W-1:0]  req_coord_1,
   input  wire logic signed [thpc_pkg::COORD_W-1:0]  req_coord_2,
   input  wire logic signed [thpc_pkg::COORD_W-1:0]  req_coord_3,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [thpc_pkg::CID_OUT_W-1:0]            rsp_cluster_id,
   output logic                                      rsp_is_new_cluster,
   output logic [thpc_pkg::CNT_OUT_W-1:0]            rsp_member_count,
   output logic                                      rsp_store_full,
   output logic signed [thpc_pkg::COORD_W-1:0]       rsp_centroid_0,
   output logic signed [thpc_pkg::COORD_W-1:0]       rsp_centroid_1,
   output logic signed [thpc_pkg::COORD_W-1:0]       rsp_centroid_2,
   output logic signed [thpc_pkg::COORD_W-1:0]       rsp_centroid_3,
   input  wire logic                                 csr_we,
   input  wire logic                                 csr_index,
   input  wire logic [thpc_pkg::THRESH_W-1:0]        csr_wdata
);

   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int LW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int PW = CW + 18;
   localparam int NW = CW + 16;

   typedef logic [MAX_DIMS-1:0][thpc_pkg::COORD_W-1:0] vec_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_MUL,
      ST_DIVGO,
      ST_DIV,
      ST_WRITE,
      ST_DONE
   } state_type;

   // memories
   vec_type       point_mem [MAX_POINTS];
   logic [IW-1:0] pcid_mem  [MAX_POINTS];
   vec_type       cent_mem  [MAX_POINTS];
   logic [CW-1:0] size_mem  [MAX_POINTS];

   vec_type       point_rd_ff;
   logic [IW-1:0] pcid_rd_ff;
   vec_type       cent_rd_ff;
   logic [CW-1:0] size_rd_ff;

   // control and payload registers
   state_type                     state_ff, state_in;
   vec_type                       pt_ff, pt_in;
   logic [CW-1:0]                 stored_ff, stored_in;
   logic [CW-1:0]                 clusters_ff, clusters_in;
   logic [CW-1:0]                 scan_ff, scan_in;
   logic [IW-1:0]                 best_ff, best_in;
   logic                          found_ff, found_in;
   logic [LW-1:0]                 lane_ff, lane_in;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic                          neg_ff, neg_in;
   vec_type                       newc_ff, newc_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic [thpc_pkg::THRESH_W-1:0] thresh_ff, thresh_in;
   logic [thpc_pkg::DIMS_W-1:0]   dims_ff, dims_in;
   logic [31:0]                   th2_ff;

   logic [IW-1:0]                 res_cid_ff, res_cid_in;
   logic                          res_new_ff, res_new_in;
   logic [CW-1:0]                 res_cnt_ff, res_cnt_in;
   logic                          res_full_ff, res_full_in;
   thpc_pkg::coord_vec_type       res_cent_ff, res_cent_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [thpc_pkg::CID_OUT_W-1:0] rsp_cid_ff, rsp_cid_in;
   logic                          rsp_new_ff, rsp_new_in;
   logic [thpc_pkg::CNT_OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                          rsp_full_ff, rsp_full_in;
   thpc_pkg::coord_vec_type       rsp_cent_ff, rsp_cent_in;

   // memory write controls
   logic                          pmem_we;
   logic                          cmem_we;
   logic [IW-1:0]                 cmem_addr;
   vec_type                       cmem_data;
   logic [CW-1:0]                 smem_data;

   // other datapath signals
   thpc_pkg::coord_vec_type       req_vec;
   thpc_pkg::coord_vec_type       masked_newc;
   thpc_pkg::coord_vec_type       masked_pt;
   logic [thpc_pkg::DIMS_W-1:0]   dims_eff;
   logic                          accept;
   logic [CW-1:0]                 stored_start;
   logic                          issue;
   logic                          hit;
   thpc_pkg::dist_res_type        dres;
   logic [IW-1:0]                 dres_cid;
   logic signed [PW-1:0]          num;
   logic [PW-1:0]                 mag;
   logic [CW-1:0]                 den;
   logic                          div_start;
   logic [NW-1:0]                 div_dividend;
   thpc_pkg::div_status_type      div_stat;
   logic [NW-1:0]                 div_quo;
   logic [thpc_pkg::COORD_W-1:0]  rounded;

   assign req_vec = {req_coord_3, req_coord_2, req_coord_1, req_coord_0};

   // effective dimension count, saturated to 1..MAX_DIMS
   always_comb begin
      if (dims_ff == '0) begin
         dims_eff = 3'd1;
      end else if (dims_ff > 3'(MAX_DIMS)) begin
         dims_eff = 3'(MAX_DIMS);
      end else begin
         dims_eff = dims_ff;
      end
   end

   // four-lane views with unused coordinates zeroed
   always_comb begin
      masked_newc = '0;
      masked_pt   = '0;
      for (int j = 0; j < MAX_DIMS; j++) begin
         if (3'(j) < dims_eff) begin
            masked_newc[j] = newc_ff[j];
            masked_pt[j]   = pt_ff[j];
         end
      end
   end

   // distance unit over the stored points
   thpc_dist #(
      .MAX_DIMS (MAX_DIMS),
      .IW       (IW)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid_ff),
      .pt       (pt_ff),
      .st       (point_rd_ff),
      .in_cid   (pcid_rd_ff),
      .dims_eff (dims_eff),
      .th2      (th2_ff),
      .res      (dres),
      .res_cid  (dres_cid)
   );

   // shared divider for the centroid update
   thpc_div #(
      .NW (NW),
      .CW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .den      (den),
      .stat     (div_stat),
      .quo      (div_quo)
   );

   // running-mean numerator and rounding offset
   always_comb begin
      num          = prod_ff + PW'($signed(pt_ff[lane_ff]));
      mag          = num[PW-1] ? PW'(-num) : PW'(num);
      den          = size_rd_ff + 1'b1;
      div_dividend = NW'(mag) + NW'(den >> 1);
   end

   // signed, saturated quotient
   always_comb begin
      if (neg_ff) begin
         rounded = (div_quo > NW'(32768)) ? 16'h8000 : 16'(-div_quo);
      end else begin
         rounded = (div_quo > NW'(32767)) ? 16'h7fff : div_quo[15:0];
      end
   end

   assign accept       = req_valid && req_ready;
   assign stored_start = req_start_new_set ? '0 : stored_ff;
   assign issue        = (scan_ff < stored_ff);
   assign hit          = dres.valid && dres.in_range && (!found_ff || (dres_cid < best_ff));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pt_in        = pt_ff;
      stored_in    = stored_ff;
      clusters_in  = clusters_ff;
      scan_in      = scan_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      lane_in      = lane_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      newc_in      = newc_ff;
      rd_valid_in  = 1'b0;
      thresh_in    = thresh_ff;
      dims_in      = dims_ff;
      res_cid_in   = res_cid_ff;
      res_new_in   = res_new_ff;
      res_cnt_in   = res_cnt_ff;
      res_full_in  = res_full_ff;
      res_cent_in  = res_cent_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cid_in   = rsp_cid_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_cent_in  = rsp_cent_ff;
      pmem_we      = 1'b0;
      cmem_we      = 1'b0;
      cmem_addr    = best_ff;
      cmem_data    = newc_ff;
      smem_data    = size_rd_ff + 1'b1;
      div_start    = 1'b0;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            thpc_pkg::REG_THRESHOLD: thresh_in = csr_wdata;
            thpc_pkg::REG_DIMS:      dims_in   = csr_wdata[thpc_pkg::DIMS_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               for (int j = 0; j < MAX_DIMS; j++) begin
                  pt_in[j] = req_vec[j];
               end
               stored_in = stored_start;
               if (req_start_new_set) begin
                  clusters_in = '0;
               end
               scan_in  = '0;
               best_in  = '0;
               found_in = 1'b0;
               if (stored_start == CW'(MAX_POINTS)) begin
                  res_cid_in  = '0;
                  res_new_in  = 1'b0;
                  res_cnt_in  = '0;
                  res_full_in = 1'b1;
                  res_cent_in = '0;
                  state_in    = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_valid_in = issue;
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (hit) begin
               best_in  = dres_cid;
               found_in = 1'b1;
            end
            if (!issue && !rd_valid_ff && !dres.valid) begin
               if (found_ff) begin
                  state_in = ST_FETCH;
               end else begin
                  // new cluster whose centroid is the point
                  cmem_we     = 1'b1;
                  cmem_addr   = clusters_ff[IW-1:0];
                  cmem_data   = pt_ff;
                  smem_data   = CW'(1);
                  pmem_we     = 1'b1;
                  res_cid_in  = clusters_ff[IW-1:0];
                  res_new_in  = 1'b1;
                  res_cnt_in  = CW'(1);
                  res_full_in = 1'b0;
                  res_cent_in = masked_pt;
                  clusters_in = clusters_ff + 1'b1;
                  stored_in   = stored_ff + 1'b1;
                  state_in    = ST_DONE;
               end
            end
         end
         ST_FETCH: begin
            newc_in  = cent_rd_ff;
            lane_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PW'($signed(cent_rd_ff[lane_ff])) * PW'($signed({1'b0, size_rd_ff}));
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            neg_in    = num[PW-1];
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               newc_in[lane_ff] = rounded;
               if (3'(lane_ff) + 3'd1 == dims_eff) begin
                  state_in = ST_WRITE;
               end else begin
                  lane_in  = lane_ff + 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_WRITE: begin
            cmem_we     = 1'b1;
            pmem_we     = 1'b1;
            res_cid_in  = best_ff;
            res_new_in  = 1'b0;
            res_cnt_in  = size_rd_ff + 1'b1;
            res_full_in = 1'b0;
            res_cent_in = masked_newc;
            stored_in   = stored_ff + 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cid_in   = thpc_pkg::CID_OUT_W'(res_cid_ff);
               rsp_new_in   = res_new_ff;
               rsp_cnt_in   = thpc_pkg::CNT_OUT_W'(res_cnt_ff);
               rsp_full_in  = res_full_ff;
               rsp_cent_in  = res_cent_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stored_ff    <= '0;
         clusters_ff  <= '0;
         found_ff     <= 1'b0;
         rd_valid_ff  <= 1'b0;
         thresh_ff    <= thpc_pkg::THRESH_RESET;
         dims_ff      <= thpc_pkg::DIMS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stored_ff    <= stored_in;
         clusters_ff  <= clusters_in;
         found_ff     <= found_in;
         rd_valid_ff  <= rd_valid_in;
         thresh_ff    <= thresh_in;
         dims_ff      <= dims_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pt_ff       <= pt_in;
      scan_ff     <= scan_in;
      best_ff     <= best_in;
      lane_ff     <= lane_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      newc_ff     <= newc_in;
      th2_ff      <= 32'(thresh_ff) * 32'(thresh_ff);
      res_cid_ff  <= res_cid_in;
      res_new_ff  <= res_new_in;
      res_cnt_ff  <= res_cnt_in;
      res_full_ff <= res_full_in;
      res_cent_ff <= res_cent_in;
      rsp_cid_ff  <= rsp_cid_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_full_ff <= rsp_full_in;
      rsp_cent_ff <= rsp_cent_in;
   end

   // point store and cluster store
   always_ff @(posedge clock) begin
      if (pmem_we) begin
         point_mem[stored_ff[IW-1:0]] <= pt_ff;
         pcid_mem[stored_ff[IW-1:0]]  <= cmem_addr;
      end
      if (cmem_we) begin
         cent_mem[cmem_addr] <= cmem_data;
         size_mem[cmem_addr] <= smem_data;
      end
      point_rd_ff <= point_mem[scan_ff[IW-1:0]];
      pcid_rd_ff  <= pcid_mem[scan_ff[IW-1:0]];
      cent_rd_ff  <= cent_mem[best_ff];
      size_rd_ff  <= size_mem[best_ff];
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cluster_id     = rsp_cid_ff;
   assign rsp_is_new_cluster = rsp_new_ff;
   assign rsp_member_count   = rsp_cnt_ff;
   assign rsp_store_full     = rsp_full_ff;
   assign rsp_centroid_0     = rsp_cent_ff[0];
   assign rsp_centroid_1     = rsp_cent_ff[1];
   assign rsp_centroid_2     = rsp_cent_ff[2];
   assign rsp_centroid_3     = rsp_cent_ff[3];

   `THPC_ASSERT_ALWAYS(a_stored_bound, stored_ff <= CW'(MAX_POINTS), "point count above store depth")
   `THPC_ASSERT_ALWAYS(a_clusters_bound, clusters_ff <= stored_ff, "more clusters than stored points")
   `THPC_ASSERT_IMP(a_full_clean, rsp_valid_ff && rsp_full_ff, (rsp_cnt_ff == '0) && !rsp_new_ff, "dropped point with non-zero fields")
   `THPC_ASSERT_IMP(a_scan_idle_div, state_ff == ST_SCAN, !div_stat.busy, "divider busy during scan")

endmodule

`default_nettype wire
